@@ rtl/dcs_pkg.sv @@
package dcs_pkg;

  localparam int SLOTS_DEFAULT  = 100;
  localparam int DIGITS_DEFAULT = 6;
  localparam int OUT_DIGITS     = 6;

  localparam logic [1:0] KIND_SET  = 2'd0;
  localparam logic [1:0] KIND_FADE = 2'd1;
  localparam logic [1:0] KIND_TICK = 2'd2;

  localparam logic [1:0] PHASE_IDLE   = 2'd0;
  localparam logic [1:0] PHASE_FIRST  = 2'd1;
  localparam logic [1:0] PHASE_SECOND = 2'd2;

  localparam logic [3:0]  BLANK_IDX   = 4'd10;
  localparam logic [15:0] TICKS_RESET = 16'd50;
  localparam logic [7:0]  DOTS_RESET  = 8'hFF;

  localparam longint PI_Q30  = 64'sd3373259426;
  localparam longint ONE_Q30 = 64'sd1073741824;

  typedef logic [3:0] digit_t;

  typedef struct packed {
    logic idle;
    logic adv;
  } share_ctl_t;

  typedef struct packed {
    logic [15:0] cur;
    logic [15:0] nxt;
  } share_t;

  // saturate to 99, then tens via multiply by 103 >> 10
  function automatic digit_t bcd_digit(input logic [6:0] v, input logic ones);
    logic [6:0]  s;
    logic [13:0] prod;
    logic [3:0]  tens;
    logic [6:0]  rem;
    s    = (v > 7'd99) ? 7'd99 : v;
    prod = 14'(s) * 14'd103;
    tens = prod[13:10];
    rem  = s - 7'(tens) * 7'd10;
    return ones ? rem[3:0] : tens;
  endfunction

endpackage

@@ rtl/dcs_frame.sv @@
module dcs_frame #(
  parameter int DIGIT_COUNT = dcs_pkg::DIGITS_DEFAULT
) (
  input  logic [6:0]      hours,
  input  logic [6:0]      minutes,
  input  logic [6:0]      seconds,
  input  logic            hours_blank,
  input  logic            minutes_blank,
  input  logic            seconds_blank,
  output dcs_pkg::digit_t frame [DIGIT_COUNT]
);

  for (genvar gp = 0; gp < DIGIT_COUNT; gp++) begin : g_pos
    localparam int   PAIR = gp / 2;
    localparam logic ONES = (gp % 2) == 1;
    if (PAIR > 2) begin : g_blank
      assign frame[gp] = dcs_pkg::BLANK_IDX;
    end else begin : g_digit
      logic [6:0] val;
      logic       blk;
      assign val = (PAIR == 0) ? hours : (PAIR == 1) ? minutes : seconds;
      assign blk = (PAIR == 0) ? hours_blank : (PAIR == 1) ? minutes_blank : seconds_blank;
      assign frame[gp] = blk ? dcs_pkg::BLANK_IDX : dcs_pkg::bcd_digit(val, ONES);
    end
  end

endmodule

@@ rtl/dcs_share.sv @@
module dcs_share #(
  parameter int SLOTS_PER_PHASE = dcs_pkg::SLOTS_DEFAULT,
  localparam int SLOT_W = $clog2(SLOTS_PER_PHASE)
) (
  input  logic                clk,
  input  dcs_pkg::share_ctl_t ctl,
  input  logic [SLOT_W-1:0]   slot,
  input  logic [15:0]         ticks,
  output dcs_pkg::share_t     share
);

  // Q0.16 raised cosine, cos^2 by Taylor series in Q30
  function automatic logic [15:0] weight_for(input int idx);
    longint x, x2, term, sum;
    longint unsigned c, sq, w;
    x    = (dcs_pkg::PI_Q30 * longint'(idx)) / (2 * SLOTS_PER_PHASE);
    x2   = (x * x) >>> 30;
    term = dcs_pkg::ONE_Q30;
    sum  = dcs_pkg::ONE_Q30;
    term = ((term * x2) >>> 30) / 2;   sum = sum - term;
    term = ((term * x2) >>> 30) / 12;  sum = sum + term;
    term = ((term * x2) >>> 30) / 30;  sum = sum - term;
    term = ((term * x2) >>> 30) / 56;  sum = sum + term;
    term = ((term * x2) >>> 30) / 90;  sum = sum - term;
    term = ((term * x2) >>> 30) / 132; sum = sum + term;
    term = ((term * x2) >>> 30) / 182; sum = sum - term;
    term = ((term * x2) >>> 30) / 240; sum = sum + term;
    if (sum < 0) sum = 0;
    c  = longint'(sum);
    sq = c * c;
    w  = (sq + (64'd1 << 43)) >> 44;
    if (w > 64'd65535) w = 64'd65535;
    return w[15:0];
  endfunction

  localparam logic [15:0] W0 = weight_for(0);
  localparam logic [15:0] W1 = weight_for(1);

  logic [15:0]     weight_tab [SLOTS_PER_PHASE];
  logic [15:0]     w_cur;
  logic [15:0]     w_nxt;
  logic [SLOT_W:0] idx_sum;
  logic [SLOT_W:0] idx_wrap;
  logic [15:0]     w_ahead;
  logic [31:0]     rnd_cur;
  logic [31:0]     rnd_nxt;

  for (genvar gi = 0; gi < SLOTS_PER_PHASE; gi++) begin : g_tab
    localparam logic [15:0] W = weight_for(gi);
    assign weight_tab[gi] = W;
  end

  // weight two slots ahead, wrapped; shares follow the live slot_ticks
  always_comb begin
    idx_sum   = {1'b0, slot} + (SLOT_W + 1)'(2);
    idx_wrap  = (idx_sum >= (SLOT_W + 1)'(SLOTS_PER_PHASE))
              ? idx_sum - (SLOT_W + 1)'(SLOTS_PER_PHASE) : idx_sum;
    w_ahead   = weight_tab[idx_wrap[SLOT_W-1:0]];
    rnd_cur   = 32'(w_cur) * 32'(ticks) + 32'd32768;
    rnd_nxt   = 32'(w_nxt) * 32'(ticks) + 32'd32768;
    share.cur = rnd_cur[31:16];
    share.nxt = rnd_nxt[31:16];
  end

  always_ff @(posedge clk) begin
    if (ctl.idle) begin
      w_cur <= W0;
      w_nxt <= W1;
    end else if (ctl.adv) begin
      w_cur <= w_nxt;
      w_nxt <= w_ahead;
    end
  end

endmodule

@@ rtl/digit_crossfade_sequencer.sv @@
// channel | signals                        | transaction when
// --------+--------------------------------+----------------------------
// in      | in_valid, in_stall, item ports | in_valid & !in_stall
// out     | out_valid, out_stall, results  | out_valid & !out_stall
// cfg     | cfg_we, cfg_wdata (slot_ticks) | cfg_we
//
// One transaction per clock while out_stall is low; an item passes the input register, then the result register.
// Table weights of the current and next slot sit in registers; two 16x16 multipliers
// scale them by slot_ticks in the same cycle.
// rst is synchronous; control and fade state clear, shown dots go to all ones, slot_ticks returns to 50.
// A stalled result holds; one more item may wait in the input register.
module digit_crossfade_sequencer #(
  parameter int SLOTS_PER_PHASE = dcs_pkg::SLOTS_DEFAULT,
  parameter int DIGIT_COUNT     = dcs_pkg::DIGITS_DEFAULT,
  localparam int SLOT_W = $clog2(SLOTS_PER_PHASE)
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  kind,
  input  logic [6:0]  hours,
  input  logic [6:0]  minutes,
  input  logic [6:0]  seconds,
  input  logic        hours_blank,
  input  logic        minutes_blank,
  input  logic        seconds_blank,
  input  logic [7:0]  dot_bits,
  input  logic        full_blank,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  shown_d0,
  output logic [3:0]  shown_d1,
  output logic [3:0]  shown_d2,
  output logic [3:0]  shown_d3,
  output logic [3:0]  shown_d4,
  output logic [3:0]  shown_d5,
  output logic [7:0]  shown_dots,
  output logic        busy_res,
  output logic        rejected,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata
);

  logic [15:0] slot_ticks;
  logic [15:0] eff_ticks;

  logic        s1_valid;
  logic [1:0]  s1_kind;
  logic [6:0]  s1_hours;
  logic [6:0]  s1_minutes;
  logic [6:0]  s1_seconds;
  logic        s1_hours_blank;
  logic        s1_minutes_blank;
  logic        s1_seconds_blank;
  logic [7:0]  s1_dots;
  logic        s1_full_blank;
  logic        in_take;
  logic        move;

  dcs_pkg::digit_t shown_digits       [DIGIT_COUNT];
  dcs_pkg::digit_t shown_digits_next  [DIGIT_COUNT];
  dcs_pkg::digit_t from_digits        [DIGIT_COUNT];
  dcs_pkg::digit_t from_digits_next   [DIGIT_COUNT];
  dcs_pkg::digit_t middle_digits      [DIGIT_COUNT];
  dcs_pkg::digit_t middle_digits_next [DIGIT_COUNT];
  dcs_pkg::digit_t target_digits      [DIGIT_COUNT];
  dcs_pkg::digit_t target_digits_next [DIGIT_COUNT];
  dcs_pkg::digit_t new_frame          [DIGIT_COUNT];
  dcs_pkg::digit_t res_digits         [DIGIT_COUNT];
  logic [3:0]      port_d             [dcs_pkg::OUT_DIGITS];

  logic [7:0]        shown_dot_bits, shown_dot_bits_next;
  logic [7:0]        dots_old, dots_old_next;
  logic [7:0]        dots_mid, dots_mid_next;
  logic [7:0]        dots_new, dots_new_next;
  logic [1:0]        fade_phase, fade_phase_next;
  logic [SLOT_W-1:0] slot_index, slot_index_next;
  logic              showing_next, showing_next_next;
  logic [15:0]       tick_count, tick_count_next;
  logic [16:0]       tc_inc;
  logic              busy;
  logic              rej;
  logic              slot_end;
  logic              fade_done;

  logic [7:0] res_dots;
  logic       res_busy;
  logic       res_rej;

  dcs_pkg::share_ctl_t share_ctl;
  dcs_pkg::share_t     share;

  assign eff_ticks = (slot_ticks == 16'd0) ? 16'd1 : slot_ticks;
  assign in_stall  = s1_valid && out_valid && out_stall;
  assign in_take   = in_valid && !in_stall;
  assign move      = s1_valid && !(out_valid && out_stall);
  assign busy      = fade_phase != dcs_pkg::PHASE_IDLE;
  assign tc_inc    = {1'b0, tick_count} + 17'd1;
  assign slot_end  = tc_inc >= {1'b0, eff_ticks};

  assign share_ctl.idle = !busy;
  assign share_ctl.adv  = move && (s1_kind == dcs_pkg::KIND_TICK) && busy && slot_end;

  dcs_frame #(.DIGIT_COUNT(DIGIT_COUNT)) u_frame (
    .hours         (s1_hours),
    .minutes       (s1_minutes),
    .seconds       (s1_seconds),
    .hours_blank   (s1_hours_blank),
    .minutes_blank (s1_minutes_blank),
    .seconds_blank (s1_seconds_blank),
    .frame         (new_frame)
  );

  dcs_share #(.SLOTS_PER_PHASE(SLOTS_PER_PHASE)) u_share (
    .clk   (clk),
    .ctl   (share_ctl),
    .slot  (slot_index),
    .ticks (eff_ticks),
    .share (share)
  );

  always_comb begin
    shown_digits_next   = shown_digits;
    from_digits_next    = from_digits;
    middle_digits_next  = middle_digits;
    target_digits_next  = target_digits;
    shown_dot_bits_next = shown_dot_bits;
    dots_old_next       = dots_old;
    dots_mid_next       = dots_mid;
    dots_new_next       = dots_new;
    fade_phase_next     = fade_phase;
    slot_index_next     = slot_index;
    showing_next_next   = showing_next;
    tick_count_next     = tick_count;
    fade_done           = 1'b0;
    rej = busy && (s1_kind == dcs_pkg::KIND_SET || s1_kind == dcs_pkg::KIND_FADE);
    case (s1_kind)
      dcs_pkg::KIND_SET: begin
        if (!busy) begin
          shown_digits_next   = new_frame;
          shown_dot_bits_next = s1_dots;
        end
      end
      dcs_pkg::KIND_FADE: begin
        if (!busy) begin
          from_digits_next   = shown_digits;
          target_digits_next = new_frame;
          dots_old_next      = shown_dot_bits;
          dots_new_next      = s1_dots;
          for (int p = 0; p < DIGIT_COUNT; p++) begin
            if (s1_full_blank || shown_digits[p] != new_frame[p]) begin
              middle_digits_next[p] = dcs_pkg::BLANK_IDX;
            end else begin
              middle_digits_next[p] = new_frame[p];
            end
          end
          dots_mid_next = (s1_full_blank || shown_dot_bits != s1_dots) ? 8'd0 : s1_dots;
          fade_phase_next   = dcs_pkg::PHASE_FIRST;
          slot_index_next   = '0;
          tick_count_next   = 16'd0;
          showing_next_next = share.cur == 16'd0;
          if (showing_next_next) begin
            shown_digits_next   = middle_digits_next;
            shown_dot_bits_next = dots_mid_next;
          end
        end
      end
      dcs_pkg::KIND_TICK: begin
        if (busy) begin
          if (slot_end) begin
            tick_count_next   = 16'd0;
            showing_next_next = share.nxt == 16'd0;
            if (slot_index == SLOT_W'(SLOTS_PER_PHASE - 1)) begin
              slot_index_next = '0;
              if (fade_phase == dcs_pkg::PHASE_FIRST) begin
                fade_phase_next = dcs_pkg::PHASE_SECOND;
              end else begin
                fade_phase_next = dcs_pkg::PHASE_IDLE;
                fade_done       = 1'b1;
              end
            end else begin
              slot_index_next = slot_index + SLOT_W'(1);
            end
          end else begin
            tick_count_next = tc_inc[15:0];
            if (tc_inc >= {1'b0, share.cur}) showing_next_next = 1'b1;
          end
          if (fade_done) begin
            showing_next_next   = 1'b0;
            shown_digits_next   = target_digits;
            shown_dot_bits_next = dots_new;
          end else if (fade_phase_next == dcs_pkg::PHASE_FIRST) begin
            shown_digits_next   = showing_next_next ? middle_digits : from_digits;
            shown_dot_bits_next = showing_next_next ? dots_mid : dots_old;
          end else begin
            shown_digits_next   = showing_next_next ? target_digits : middle_digits;
            shown_dot_bits_next = showing_next_next ? dots_new : dots_mid;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_ticks <= dcs_pkg::TICKS_RESET;
    end else if (cfg_we) begin
      slot_ticks <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_take) s1_valid <= 1'b1;
      else if (move) s1_valid <= 1'b0;
      if (move) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_kind          <= kind;
      s1_hours         <= hours;
      s1_minutes       <= minutes;
      s1_seconds       <= seconds;
      s1_hours_blank   <= hours_blank;
      s1_minutes_blank <= minutes_blank;
      s1_seconds_blank <= seconds_blank;
      s1_dots          <= dot_bits;
      s1_full_blank    <= full_blank;
    end
    if (move) begin
      res_digits <= shown_digits_next;
      res_dots   <= shown_dot_bits_next;
      res_busy   <= fade_phase_next != dcs_pkg::PHASE_IDLE;
      res_rej    <= rej;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int p = 0; p < DIGIT_COUNT; p++) begin
        shown_digits[p]  <= 4'd0;
        from_digits[p]   <= 4'd0;
        middle_digits[p] <= 4'd0;
        target_digits[p] <= 4'd0;
      end
      shown_dot_bits <= dcs_pkg::DOTS_RESET;
      dots_old       <= 8'd0;
      dots_mid       <= 8'd0;
      dots_new       <= 8'd0;
      fade_phase     <= dcs_pkg::PHASE_IDLE;
      slot_index     <= '0;
      showing_next   <= 1'b0;
      tick_count     <= 16'd0;
    end else if (move) begin
      shown_digits   <= shown_digits_next;
      from_digits    <= from_digits_next;
      middle_digits  <= middle_digits_next;
      target_digits  <= target_digits_next;
      shown_dot_bits <= shown_dot_bits_next;
      dots_old       <= dots_old_next;
      dots_mid       <= dots_mid_next;
      dots_new       <= dots_new_next;
      fade_phase     <= fade_phase_next;
      slot_index     <= slot_index_next;
      showing_next   <= showing_next_next;
      tick_count     <= tick_count_next;
    end
  end

  for (genvar gp = 0; gp < dcs_pkg::OUT_DIGITS; gp++) begin : g_out
    if (gp < DIGIT_COUNT) begin : g_used
      assign port_d[gp] = res_digits[gp];
    end else begin : g_none
      assign port_d[gp] = dcs_pkg::BLANK_IDX;
    end
  end

  assign shown_d0   = port_d[0];
  assign shown_d1   = port_d[1];
  assign shown_d2   = port_d[2];
  assign shown_d3   = port_d[3];
  assign shown_d4   = port_d[4];
  assign shown_d5   = port_d[5];
  assign shown_dots = res_dots;
  assign busy_res   = res_busy;
  assign rejected   = res_rej;

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

  localparam int SLOTS = dcs_pkg::SLOTS_DEFAULT;
  localparam int WATCHDOG = 4000;
  localparam int HOLD_CYCLES = 80;
  localparam logic [1:0] KIND_NONE = 2'd3;

  typedef longint unsigned u64_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [6:0] hours;
    logic [6:0] minutes;
    logic [6:0] seconds;
    logic       hours_blank;
    logic       minutes_blank;
    logic       seconds_blank;
    logic [7:0] dot_bits;
    logic       full_blank;
  } clock_req_t;

  typedef struct packed {
    logic [5:0][3:0] digit;
    logic [7:0]      dots;
    logic            busy;
    logic            rejected;
  } display_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  clock_req_t  cur_req = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [3:0]  shown_d0, shown_d1, shown_d2, shown_d3, shown_d4, shown_d5;
  logic [7:0]  shown_dots;
  logic        busy_res;
  logic        rejected;
  logic        cfg_we = 1'b0;
  logic [15:0] cfg_wdata = '0;

  clock_req_t item_q[$];
  display_t   display_q[$];
  int errors = 0;
  int send_idle_pct = 6;
  int recv_idle_pct = 53;
  int hold_asks = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int quiet = 0;

  // display model state
  logic [15:0]     cos_w [SLOTS];
  logic [15:0]     cfg_ticks = dcs_pkg::TICKS_RESET;
  logic [5:0][3:0] disp_dig = '0;
  logic [7:0]      disp_dots = dcs_pkg::DOTS_RESET;
  logic [5:0][3:0] from_dig = '0;
  logic [5:0][3:0] mid_dig = '0;
  logic [5:0][3:0] to_dig = '0;
  logic [7:0]      fdots [3] = '{8'h00, 8'h00, 8'h00};
  logic [1:0]      fphase = dcs_pkg::PHASE_IDLE;
  int              slot = 0;
  bit              nxt = 1'b0;
  int              tcount = 0;

  // stimulus generator state
  int         fade_left = 0;
  clock_req_t last_req = '0;

  digit_crossfade_sequencer uut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .kind          (cur_req.kind),
    .hours         (cur_req.hours),
    .minutes       (cur_req.minutes),
    .seconds       (cur_req.seconds),
    .hours_blank   (cur_req.hours_blank),
    .minutes_blank (cur_req.minutes_blank),
    .seconds_blank (cur_req.seconds_blank),
    .dot_bits      (cur_req.dot_bits),
    .full_blank    (cur_req.full_blank),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .shown_d0      (shown_d0),
    .shown_d1      (shown_d1),
    .shown_d2      (shown_d2),
    .shown_d3      (shown_d3),
    .shown_d4      (shown_d4),
    .shown_d5      (shown_d5),
    .shown_dots    (shown_dots),
    .busy_res      (busy_res),
    .rejected      (rejected),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // raised-cosine weight: cos^2(pi*i/2S) via Q30 Taylor series, rounded to Q16
  function automatic logic [15:0] cos_weight(int i);
    longint x, x2, term, sum;
    u64_t c, sq, w;
    x = (dcs_pkg::PI_Q30 * i) / (2 * SLOTS);
    x2 = (x * x) / dcs_pkg::ONE_Q30;
    term = dcs_pkg::ONE_Q30;
    sum = dcs_pkg::ONE_Q30;
    for (int k = 1; k <= 8; k++) begin
      term = (term * x2) / dcs_pkg::ONE_Q30;
      term = term / ((2 * k - 1) * (2 * k));
      if (k % 2 == 1) sum = sum - term;
      else sum = sum + term;
    end
    if (sum < 0) sum = 0;
    c = sum;
    sq = c * c;
    w = (sq + (u64_t'(1) << 43)) >> 44;
    return (w > 65535) ? 16'hFFFF : w[15:0];
  endfunction

  function automatic int old_share(int s);
    u64_t w, e;
    w = (s < SLOTS) ? u64_t'(cos_w[s]) : 0;
    e = (cfg_ticks == 0) ? 1 : u64_t'(cfg_ticks);
    return int'((w * e + 32768) >> 16);
  endfunction

  function automatic logic [5:0][3:0] frame_of(clock_req_t r);
    logic [5:0][3:0] f;
    logic [6:0] v [3];
    logic b [3];
    int s;
    v = '{r.hours, r.minutes, r.seconds};
    b = '{r.hours_blank, r.minutes_blank, r.seconds_blank};
    for (int p = 0; p < 3; p++) begin
      s = (v[p] > 99) ? 99 : int'(v[p]);
      f[2*p]   = b[p] ? dcs_pkg::BLANK_IDX : 4'(s / 10);
      f[2*p+1] = b[p] ? dcs_pkg::BLANK_IDX : 4'(s % 10);
    end
    return f;
  endfunction

  function automatic void show_phase_frame();
    if (fphase == dcs_pkg::PHASE_FIRST) begin
      disp_dig = nxt ? mid_dig : from_dig;
      disp_dots = nxt ? fdots[1] : fdots[0];
    end else if (fphase == dcs_pkg::PHASE_SECOND) begin
      disp_dig = nxt ? to_dig : mid_dig;
      disp_dots = nxt ? fdots[2] : fdots[1];
    end
  endfunction

  function automatic void count_tick();
    int e;
    e = (cfg_ticks == 0) ? 1 : int'(cfg_ticks);
    tcount++;
    if (tcount >= e) begin
      tcount = 0;
      slot++;
      if (slot >= SLOTS) begin
        slot = 0;
        if (fphase == dcs_pkg::PHASE_FIRST) begin
          fphase = dcs_pkg::PHASE_SECOND;
        end else begin
          fphase = dcs_pkg::PHASE_IDLE;
          nxt = 1'b0;
          disp_dig = to_dig;
          disp_dots = fdots[2];
          return;
        end
      end
      nxt = (old_share(slot) == 0);
    end else if (tcount >= old_share(slot)) begin
      nxt = 1'b1;
    end
    show_phase_frame();
  endfunction

  function automatic display_t next_display(clock_req_t r);
    display_t d;
    logic rej;
    rej = 1'b0;
    if (r.kind == dcs_pkg::KIND_SET || r.kind == dcs_pkg::KIND_FADE) begin
      if (fphase != dcs_pkg::PHASE_IDLE) begin
        rej = 1'b1;
      end else if (r.kind == dcs_pkg::KIND_SET) begin
        disp_dig = frame_of(r);
        disp_dots = r.dot_bits;
      end else begin
        from_dig = disp_dig;
        to_dig = frame_of(r);
        fdots[0] = disp_dots;
        fdots[2] = r.dot_bits;
        if (r.full_blank) begin
          mid_dig = {6{dcs_pkg::BLANK_IDX}};
          fdots[1] = 8'h00;
        end else begin
          for (int p = 0; p < 6; p++)
            mid_dig[p] = (from_dig[p] != to_dig[p]) ? dcs_pkg::BLANK_IDX : to_dig[p];
          fdots[1] = (disp_dots != r.dot_bits) ? 8'h00 : r.dot_bits;
        end
        fphase = dcs_pkg::PHASE_FIRST;
        slot = 0;
        tcount = 0;
        nxt = (old_share(0) == 0);
        show_phase_frame();
      end
    end else if (r.kind == dcs_pkg::KIND_TICK && fphase != dcs_pkg::PHASE_IDLE) begin
      count_tick();
    end
    d.digit = disp_dig;
    d.dots = disp_dots;
    d.busy = (fphase != dcs_pkg::PHASE_IDLE);
    d.rejected = rej;
    return d;
  endfunction

  task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  function automatic clock_req_t mk(logic [1:0] k, logic [6:0] h, logic [6:0] m, logic [6:0] s,
                                    logic hb, logic mb, logic sb, logic [7:0] d, logic fb);
    clock_req_t r;
    r = '{kind: k, hours: h, minutes: m, seconds: s, hours_blank: hb,
          minutes_blank: mb, seconds_blank: sb, dot_bits: d, full_blank: fb};
    return r;
  endfunction

  function automatic clock_req_t noise_req(logic [1:0] k);
    clock_req_t r;
    logic [63:0] bits;
    bits = {$urandom(), $urandom()};
    r = bits[$bits(clock_req_t)-1:0];
    r.kind = k;
    return r;
  endfunction

  function automatic logic [6:0] rand_value();
    return ($urandom_range(0, 9) == 0) ? 7'($urandom_range(100, 127))
                                       : 7'($urandom_range(0, 99));
  endfunction

  // mostly small edits to the last value so unchanged digits and dots show up
  function automatic clock_req_t rand_request(logic [1:0] k);
    clock_req_t r;
    r = last_req;
    r.kind = k;
    if ($urandom_range(0, 1)) r.hours = rand_value();
    if ($urandom_range(0, 1)) r.minutes = rand_value();
    if ($urandom_range(0, 1)) r.seconds = rand_value();
    r.hours_blank = ($urandom_range(0, 4) == 0);
    r.minutes_blank = ($urandom_range(0, 4) == 0);
    r.seconds_blank = ($urandom_range(0, 4) == 0);
    if ($urandom_range(0, 1)) r.dot_bits = 8'($urandom());
    r.full_blank = ($urandom_range(0, 3) == 0);
    return r;
  endfunction

  task automatic push_ticks(int n);
    repeat (n) item_q.push_back(noise_req(dcs_pkg::KIND_TICK));
  endtask

  task automatic gen_items(int eff, int want);
    clock_req_t r;
    logic [1:0] others [3];
    int n, pick;
    others = '{dcs_pkg::KIND_SET, dcs_pkg::KIND_FADE, KIND_NONE};
    n = 0;
    while (n < want || fade_left > 0) begin
      pick = $urandom_range(0, 9);
      if (fade_left > 0) begin
        if (n >= want || pick != 0) begin
          r = noise_req(dcs_pkg::KIND_TICK);
          fade_left--;
        end else begin
          r = noise_req(others[$urandom_range(0, 2)]);
        end
      end else if (pick < 4) begin
        r = rand_request(dcs_pkg::KIND_FADE);
        last_req = r;
        fade_left = 2 * SLOTS * eff;
      end else if (pick < 7) begin
        r = rand_request(dcs_pkg::KIND_SET);
        last_req = r;
      end else begin
        r = noise_req((pick < 9) ? dcs_pkg::KIND_TICK : KIND_NONE);
        n--;
      end
      n++;
      item_q.push_back(r);
    end
  endtask

  task automatic drain();
    while (item_q.size() != 0 || in_valid || display_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_ticks(logic [15:0] t);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= t;
    @(posedge clk);
    cfg_we <= 1'b0;
    cfg_ticks = t;
  endtask

  task automatic run_phase(logic [15:0] t, int want, bit hold);
    int n0;
    write_ticks(t);
    gen_items((t == 0) ? 1 : int'(t), want);
    if (hold) begin
      n0 = item_q.size();
      while (item_q.size() > n0 / 2) @(posedge clk);
      hold_asks++;
    end
    drain();
  endtask

  // driver
  always @(posedge clk) begin
    bit take;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      take = !in_valid;
      if (in_valid && !in_stall) begin
        display_q.push_back(next_display(cur_req));
        take = 1'b1;
      end
      if (take) begin
        if (item_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          cur_req <= item_q.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    display_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (display_q.size() == 0) begin
          $error("result transaction with no expectation pending");
          errors++;
        end else begin
          want = display_q.pop_front();
          check_field("shown_d0", want.digit[0], shown_d0);
          check_field("shown_d1", want.digit[1], shown_d1);
          check_field("shown_d2", want.digit[2], shown_d2);
          check_field("shown_d3", want.digit[3], shown_d3);
          check_field("shown_d4", want.digit[4], shown_d4);
          check_field("shown_d5", want.digit[5], shown_d5);
          check_field("shown_dots", want.dots, shown_dots);
          check_field("busy_res", want.busy, busy_res);
          check_field("rejected", want.rejected, rejected);
        end
      end
      if (hold_seen != hold_asks) begin
        hold_seen = hold_asks;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet <= 0;
    end else if (quiet >= WATCHDOG) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin
    for (int i = 0; i < SLOTS; i++) cos_w[i] = cos_weight(i);
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // idle behavior at the reset slot length
    item_q.push_back(mk(dcs_pkg::KIND_TICK, 0, 0, 0, 0, 0, 0, 8'h00, 0));
    item_q.push_back(mk(KIND_NONE, 127, 127, 127, 1, 1, 1, 8'hFF, 1));
    item_q.push_back(mk(dcs_pkg::KIND_SET, 0, 0, 0, 0, 0, 0, 8'h00, 0));
    item_q.push_back(mk(dcs_pkg::KIND_SET, 99, 99, 99, 0, 0, 0, 8'hFF, 1));
    item_q.push_back(mk(dcs_pkg::KIND_SET, 127, 100, 127, 0, 0, 0, 8'hA5, 0));
    item_q.push_back(mk(dcs_pkg::KIND_SET, 5, 9, 127, 1, 0, 0, 8'h5A, 0));
    item_q.push_back(mk(dcs_pkg::KIND_SET, 88, 88, 88, 1, 1, 1, 8'h3C, 1));
    item_q.push_back(mk(dcs_pkg::KIND_TICK, 127, 127, 127, 1, 1, 1, 8'hFF, 1));
    drain();

    // directed fades with one tick per slot
    write_ticks(16'd1);
    item_q.push_back(mk(dcs_pkg::KIND_SET, 12, 34, 56, 0, 0, 0, 8'h0F, 0));
    item_q.push_back(mk(dcs_pkg::KIND_FADE, 12, 35, 56, 0, 0, 0, 8'h0F, 0));
    item_q.push_back(mk(dcs_pkg::KIND_SET, 1, 2, 3, 0, 0, 0, 8'h11, 0));
    item_q.push_back(mk(dcs_pkg::KIND_FADE, 4, 5, 6, 0, 0, 0, 8'h22, 1));
    item_q.push_back(mk(KIND_NONE, 7, 8, 9, 0, 0, 0, 8'h33, 0));
    push_ticks(2 * SLOTS);
    item_q.push_back(mk(dcs_pkg::KIND_TICK, 0, 0, 0, 0, 0, 0, 8'h00, 0));
    item_q.push_back(mk(dcs_pkg::KIND_FADE, 23, 59, 59, 0, 0, 0, 8'hF0, 1));
    push_ticks(SLOTS);
    item_q.push_back(mk(dcs_pkg::KIND_SET, 10, 20, 30, 0, 0, 0, 8'h44, 0));
    push_ticks(SLOTS);
    drain();

    run_phase(16'd0, 150, 1'b0);
    send_idle_pct = 53;
    recv_idle_pct = 6;
    run_phase(16'd1, 150, 1'b1);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_phase(16'd1, 100, 1'b1);

    // longer slot: the fade cannot finish, only its first slots are exercised
    write_ticks(16'd7);
    item_q.push_back(mk(dcs_pkg::KIND_SET, 8, 30, 0, 0, 0, 0, 8'h81, 0));
    item_q.push_back(mk(dcs_pkg::KIND_FADE, 9, 30, 0, 0, 0, 1, 8'h18, 0));
    push_ticks(100);
    item_q.push_back(noise_req(dcs_pkg::KIND_SET));
    item_q.push_back(noise_req(dcs_pkg::KIND_FADE));
    push_ticks(100);
    drain();

    if (errors == 0 && display_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

@@ digit_crossfade_sequencer.f @@
rtl/dcs_pkg.sv
rtl/dcs_frame.sv
rtl/dcs_share.sv
rtl/digit_crossfade_sequencer.sv
sim/tb_top.sv
